FILE: src/touch_point_average_calibrate_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the touch point average and calibrate unit
// Concurrent assertion wrappers that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef TOUCH_POINT_AVERAGE_CALIBRATE_UNIT_MACROS_SVH
`define TOUCH_POINT_AVERAGE_CALIBRATE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define TPAC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define TPAC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TPAC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define TPAC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: src/tpac_pkg.sv
// ----------------------------------------------------------------------------
// Touch point average and calibrate package
// Shared widths, codes and the divider request and response types.
// ----------------------------------------------------------------------------
package tpac_pkg;

    localparam int COORD_W    = 12;
    localparam int FINGER_W   = 8;
    localparam int EVENT_W    = 4;
    localparam int SUM_W      = 15;
    localparam int CNT_W      = 3;
    localparam int POS_W      = 32;
    localparam int FRAC_BITS  = 16;
    localparam int DIV_W      = 34;
    localparam int DEN_W      = 32;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    localparam logic [EVENT_W-1:0]  CONTACT_EVENT = 4'h8;
    localparam logic [FINGER_W-1:0] FINGER_LIMIT  = 8'd5;

    typedef enum logic [1:0] {
        REG_X_BIAS  = 2'd0,
        REG_RATIO_X = 2'd1,
        REG_Y_BIAS  = 2'd2,
        REG_RATIO_Y = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic             busy;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

FILE: src/tpac_in_if.sv
// ----------------------------------------------------------------------------
// Point record channel
// Valid/ready channel that carries one touch point record per item.
// ----------------------------------------------------------------------------
interface tpac_in_if;
    import tpac_pkg::*;

    logic                valid;
    logic                ready;
    logic [FINGER_W-1:0] finger_count;
    logic [EVENT_W-1:0]  event_kind;
    logic [COORD_W-1:0]  raw_y;
    logic [COORD_W-1:0]  raw_x;
    logic                last;

    modport source (output valid, finger_count, event_kind, raw_y, raw_x, last,
                    input ready);
    modport sink   (input valid, finger_count, event_kind, raw_y, raw_x, last,
                    output ready);
endinterface

FILE: src/tpac_out_if.sv
// ----------------------------------------------------------------------------
// Touch result channel
// Valid/ready channel that carries one calibrated touch result per item.
// ----------------------------------------------------------------------------
interface tpac_out_if;
    import tpac_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    touched;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;

    modport source (output valid, touched, pos_x, pos_y, input ready);
    modport sink   (input valid, touched, pos_x, pos_y, output ready);
endinterface

FILE: src/tpac_div.sv
// ----------------------------------------------------------------------------
// Shared restoring divider
// Unsigned divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "touch_point_average_calibrate_unit_macros.svh"

module tpac_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  tpac_pkg::div_req_t req,
    output tpac_pkg::div_rsp_t rsp
);
    import tpac_pkg::*;

    localparam int STEP_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DEN_W:0]    shifted;
    logic [DEN_W+1:0]  diff;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIV_W-1]};
        diff      = {1'b0, shifted} - {2'b00, den_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
            step_next = STEP_W'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // A non-negative trial difference means the divisor fits.
            if (!diff[DEN_W+1])
            begin
                rem_next = diff[DEN_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DEN_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.busy     = busy_reg;
    assign rsp.quotient = quo_reg;

    `TPAC_ASSERT_IMP(a_fell_done, clk, rst_n, $fell(busy_reg), done_reg, "divider ended without done")
    `TPAC_ASSERT_NXT(a_done_pulse, clk, rst_n, done_reg, !done_reg, "divider done held too long")
    `TPAC_ASSERT_IMP(a_busy_steps, clk, rst_n, busy_reg, step_reg != '0, "divider busy with no steps left")

endmodule

FILE: src/touch_point_average_calibrate_unit.sv
// ----------------------------------------------------------------------------
// Touch point average and calibrate unit
// Averages the contact points of one scan and applies linear calibration.
// ----------------------------------------------------------------------------
// A scan arrives as a run of point record items; the item with last set
// closes it. A closing record that yields a touch runs four divisions on
// one shared restoring divider (average X, average Y, calibrated X,
// calibrated Y), each producing 34 quotient bits; an axis with a zero
// ratio skips its division. A closing record with no valid touch goes
// straight to the write step. The write step waits while an earlier
// result is still uncollected, and no record is taken until the closing
// work is done. Records past MAX_POINTS in a scan are not accumulated,
// though one with last set still closes the scan. The result sits in an
// output register, so new records are taken while it waits to be
// collected.
`include "touch_point_average_calibrate_unit_macros.svh"

module touch_point_average_calibrate_unit
#(
    parameter int MAX_POINTS = 5
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    tpac_in_if.sink                       point,
    tpac_out_if.source                    result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpac_pkg::PADDR_W-1:0]  paddr,
    input  logic [tpac_pkg::PDATA_W-1:0]  pwdata,
    output logic [tpac_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import tpac_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_AVGX  = 6'b000010,
        S_AVGY  = 6'b000100,
        S_CALX  = 6'b001000,
        S_CALY  = 6'b010000,
        S_WRITE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers, two's complement 16.16 values.
    logic [POS_W-1:0] x_bias_reg, ratio_x_reg, y_bias_reg, ratio_y_reg;

    // Per-scan accumulation.
    logic [SUM_W-1:0] sum_x_reg, sum_x_next;
    logic [SUM_W-1:0] sum_y_reg, sum_y_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] idx_reg, idx_next;

    // Working values of the closing sequence.
    logic [SUM_W-1:0] avg_x_reg, avg_x_next;
    logic [SUM_W-1:0] avg_y_reg, avg_y_next;
    logic [POS_W-1:0] pos_x_reg, pos_x_next;
    logic [POS_W-1:0] pos_y_reg, pos_y_next;
    logic             touched_reg, touched_next;
    logic             neg_reg, neg_next;
    logic             launch_reg, launch_next;

    // Output register.
    logic             out_valid_reg, out_valid_next;
    logic             out_touched_reg;
    logic [POS_W-1:0] out_pos_x_reg, out_pos_y_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic             accept;
    logic             rec_take;
    logic             is_contact;
    logic             fingers_ok;
    logic             out_load;
    logic             cal_y;
    logic             div_state;
    logic             cal_state;
    logic [SUM_W-1:0] cal_avg;
    logic [POS_W-1:0] cal_off;
    logic [POS_W-1:0] cal_ratio;
    logic [DIV_W-1:0] cal_num;
    logic [DIV_W-1:0] cal_num_abs;
    logic [DEN_W-1:0] cal_ratio_abs;
    logic             ratio_zero;
    logic [POS_W-1:0] sat_val;
    logic             cfg_write;

    tpac_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // Configuration port. Every write completes in its access cycle.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_X_BIAS:  prdata = x_bias_reg;
            REG_RATIO_X: prdata = ratio_x_reg;
            REG_Y_BIAS:  prdata = y_bias_reg;
            REG_RATIO_Y: prdata = ratio_y_reg;
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_bias_reg  <= '0;
            ratio_x_reg <= '0;
            y_bias_reg  <= '0;
            ratio_y_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx_t'(paddr[3:2]))
                REG_X_BIAS:  x_bias_reg  <= pwdata;
                REG_RATIO_X: ratio_x_reg <= pwdata;
                REG_Y_BIAS:  y_bias_reg  <= pwdata;
                REG_RATIO_Y: ratio_y_reg <= pwdata;
                default:     ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Record intake. Records are only taken between scans' closing work.
    // ------------------------------------------------------------------
    assign point.ready = (state_reg == S_IDLE);
    assign accept      = point.valid && point.ready;
    assign rec_take    = (idx_reg < CNT_W'(MAX_POINTS));
    assign is_contact  = (point.event_kind == CONTACT_EVENT);
    assign fingers_ok  = (point.finger_count != '0) && (point.finger_count <= FINGER_LIMIT);

    // ------------------------------------------------------------------
    // Calibration operands for the axis now in progress. The numerator
    // (avg << 16) - offset needs 34 signed bits; the divider works on
    // magnitudes and the sign is applied after the quotient returns.
    // ------------------------------------------------------------------
    assign cal_y         = (state_reg == S_CALY);
    assign cal_state     = (state_reg == S_CALX) || (state_reg == S_CALY);
    assign div_state     = (state_reg == S_AVGX) || (state_reg == S_AVGY) || cal_state;
    assign cal_avg       = cal_y ? avg_y_reg : avg_x_reg;
    assign cal_off       = cal_y ? y_bias_reg : x_bias_reg;
    assign cal_ratio     = cal_y ? ratio_y_reg : ratio_x_reg;
    assign ratio_zero    = (cal_ratio == '0);
    assign cal_num       = {3'b000, cal_avg, {FRAC_BITS{1'b0}}}
                         - {{(DIV_W-POS_W){cal_off[POS_W-1]}}, cal_off};
    assign cal_num_abs   = cal_num[DIV_W-1] ? (~cal_num + DIV_W'(1)) : cal_num;
    assign cal_ratio_abs = cal_ratio[POS_W-1] ? (~cal_ratio + DEN_W'(1)) : cal_ratio;

    always_comb
    begin
        div_req.start    = div_state && !launch_reg && !(cal_state && ratio_zero);
        div_req.dividend = '0;
        div_req.divisor  = '0;
        if (cal_state)
        begin
            div_req.dividend = cal_num_abs;
            div_req.divisor  = cal_ratio_abs;
        end
        else if (state_reg == S_AVGY)
        begin
            div_req.dividend = DIV_W'(sum_y_reg);
            div_req.divisor  = DEN_W'(cnt_reg);
        end
        else
        begin
            div_req.dividend = DIV_W'(sum_x_reg);
            div_req.divisor  = DEN_W'(cnt_reg);
        end
    end

    // Sign and saturate the magnitude quotient to 32-bit signed.
    always_comb
    begin
        if (neg_reg)
        begin
            if (div_rsp.quotient > DIV_W'(33'h080000000))
            begin
                sat_val = 32'h80000000;
            end
            else
            begin
                sat_val = ~div_rsp.quotient[POS_W-1:0] + POS_W'(1);
            end
        end
        else
        begin
            if (div_rsp.quotient > DIV_W'(32'h7FFFFFFF))
            begin
                sat_val = 32'h7FFFFFFF;
            end
            else
            begin
                sat_val = div_rsp.quotient[POS_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    assign out_load = (state_reg == S_WRITE) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next     = state_reg;
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        avg_x_next     = avg_x_reg;
        avg_y_next     = avg_y_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        touched_next   = touched_reg;
        neg_next       = neg_reg;
        launch_next    = launch_reg;
        out_valid_next = out_valid_reg && !result.ready;

        if (div_req.start)
        begin
            launch_next = 1'b1;
            neg_next    = cal_num[DIV_W-1] ^ cal_ratio[POS_W-1];
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (rec_take)
                    begin
                        if (is_contact)
                        begin
                            sum_x_next = sum_x_reg + SUM_W'(point.raw_x);
                            sum_y_next = sum_y_reg + SUM_W'(point.raw_y);
                            cnt_next   = cnt_reg + CNT_W'(1);
                        end
                        idx_next = idx_reg + CNT_W'(1);
                    end
                    if (point.last)
                    begin
                        // A scan with a plausible finger count and at least
                        // one contact is averaged; anything else reports
                        // no touch at once.
                        if (fingers_ok && (cnt_next != '0))
                        begin
                            touched_next = 1'b1;
                            state_next   = S_AVGX;
                        end
                        else
                        begin
                            touched_next = 1'b0;
                            pos_x_next   = '0;
                            pos_y_next   = '0;
                            state_next   = S_WRITE;
                        end
                    end
                end
            end
            S_AVGX:
            begin
                if (div_rsp.done)
                begin
                    avg_x_next  = div_rsp.quotient[SUM_W-1:0];
                    launch_next = 1'b0;
                    state_next  = S_AVGY;
                end
            end
            S_AVGY:
            begin
                if (div_rsp.done)
                begin
                    avg_y_next  = div_rsp.quotient[SUM_W-1:0];
                    launch_next = 1'b0;
                    state_next  = S_CALX;
                end
            end
            S_CALX:
            begin
                if (ratio_zero)
                begin
                    // A zero ratio passes the average straight through.
                    pos_x_next = POS_W'(avg_x_reg);
                    state_next = S_CALY;
                end
                else if (div_rsp.done)
                begin
                    pos_x_next  = sat_val;
                    launch_next = 1'b0;
                    state_next  = S_CALY;
                end
            end
            S_CALY:
            begin
                if (ratio_zero)
                begin
                    pos_y_next = POS_W'(avg_y_reg);
                    state_next = S_WRITE;
                end
                else if (div_rsp.done)
                begin
                    pos_y_next  = sat_val;
                    launch_next = 1'b0;
                    state_next  = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    sum_x_next     = '0;
                    sum_y_next     = '0;
                    cnt_next       = '0;
                    idx_next       = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            launch_reg    <= launch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        avg_x_reg   <= avg_x_next;
        avg_y_reg   <= avg_y_next;
        pos_x_reg   <= pos_x_next;
        pos_y_reg   <= pos_y_next;
        touched_reg <= touched_next;
        neg_reg     <= neg_next;
        if (out_load)
        begin
            out_touched_reg <= touched_reg;
            out_pos_x_reg   <= pos_x_reg;
            out_pos_y_reg   <= pos_y_reg;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.touched = out_touched_reg;
    assign result.pos_x   = out_pos_x_reg;
    assign result.pos_y   = out_pos_y_reg;

    `TPAC_ASSERT_IMP(a_no_overwrite, clk, rst_n, out_load, !out_valid_reg || result.ready, "pending result overwritten")
    `TPAC_ASSERT_IMP(a_done_in_div, clk, rst_n, div_rsp.done, div_state && launch_reg, "divider finished outside a division step")
    `TPAC_ASSERT_IMP(a_untouched_zero, clk, rst_n, result.valid && !result.touched, result.pos_x == '0 && result.pos_y == '0, "untouched result carries a position")

endmodule
